// ===== hw/rtl/lsg_pkg.sv =====
// Shared constants, gain tables and lookup function of the lens shading gain unit.
package lsg_pkg;

  localparam int GRID_COLS = 8;
  localparam int GRID_ROWS = 6;
  localparam int XI_W = $clog2(GRID_COLS);
  localparam int YI_W = $clog2(GRID_ROWS);
  localparam int GAIN_W = 11;
  localparam int PIX_W = 16;
  localparam int COORD_W = 12;
  localparam int SIZE_W = 13;
  localparam int OUT_W = 12;
  localparam int TSEL_W = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int DEF_GAIN_FRAC_BITS = 10;
  localparam int DEF_MAX_DIM = 4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
  localparam logic [OUT_W-1:0] PIX_MAX = 12'd4095;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [ADDR_W-1:0] REG_WIDTH_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;

  localparam logic [TSEL_W-1:0] TSEL_EVEN = 2'd0;
  localparam logic [TSEL_W-1:0] TSEL_MIXED = 2'd1;
  localparam logic [TSEL_W-1:0] TSEL_ODD = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_TABLE [3][GRID_ROWS][GRID_COLS] = '{
    '{
      '{11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1824},
      '{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1324, 11'd1624},
      '{11'd1824, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724}
    },
    '{
      '{11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1784},
      '{11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1584, 11'd1664},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1524, 11'd1324, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1424, 11'd1664},
      '{11'd1724, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1554, 11'd1784}
    },
    '{
      '{11'd1224, 11'd1154, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1184, 11'd1324},
      '{11'd1164, 11'd1124, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1124, 11'd1164},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
      '{11'd1324, 11'd1224, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1264, 11'd1324},
      '{11'd1424, 11'd1264, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1314, 11'd1484}
    }
  };

  function automatic logic [GAIN_W-1:0] gain_at(input logic [TSEL_W-1:0] sel,
                                                input logic [YI_W-1:0] r,
                                                input logic [XI_W-1:0] c);
    logic [GAIN_W-1:0] g;
    case (sel)
      TSEL_EVEN: g = GAIN_TABLE[0][r][c];
      TSEL_MIXED: g = GAIN_TABLE[1][r][c];
      TSEL_ODD: g = GAIN_TABLE[2][r][c];
      default: g = GAIN_TABLE[0][r][c];
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/lsg_grid_axis.sv =====
// Serial builder of the grid node positions along one image axis.
module lsg_grid_axis #(
  parameter int COUNT = 8,
  parameter int DW = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DW-1:0]             size_m1,
  output logic                      busy,
  output logic [COUNT-1:0][DW-1:0]  nodes
);
  localparam int RW = $clog2(COUNT);
  localparam int IW = $clog2(COUNT);
  localparam int DIV_I = COUNT - 1;
  localparam int KS = DW + RW;
  localparam int MW = KS + 1;
  localparam int PRW = DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << KS) + 64'(DIV_I) - 64'd1) / 64'(DIV_I));
  localparam logic [RW:0] DIV = (RW + 1)'(DIV_I);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0] state_r;
  logic [RW-1:0] rem_r;
  logic [DW-1:0] q0_r;
  logic [DW-1:0] acc_q_r;
  logic [RW-1:0] acc_r_r;
  logic [IW-1:0] idx_r;
  logic [COUNT-1:0][DW-1:0] nodes_r;

  logic [PRW-1:0] prod_q;
  logic [DW-1:0] quo;
  logic [DW-1:0] rem_full;
  logic [RW:0] sum_r;
  logic [DW-1:0] step_q;

  assign prod_q = PRW'(size_m1) * PRW'(RECIP);
  assign quo = DW'(prod_q >> KS);
  assign rem_full = size_m1 - quo * DW'(DIV_I);
  assign sum_r = {1'b0, acc_r_r} + {1'b0, rem_r};
  assign step_q = acc_q_r + q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      state_r <= ST_DIV;
      nodes_r[0] <= '0;
    end else begin
      case (state_r)
        ST_DIV: begin
          q0_r <= quo;
          rem_r <= RW'(rem_full);
          state_r <= ST_STEP;
          idx_r <= IW'(1);
          acc_q_r <= '0;
          acc_r_r <= '0;
        end
        ST_STEP: begin
          if (sum_r >= DIV) begin
            acc_r_r <= RW'(sum_r - DIV);
            acc_q_r <= step_q + DW'(1);
            nodes_r[idx_r] <= step_q + DW'(1);
          end else begin
            acc_r_r <= RW'(sum_r);
            acc_q_r <= step_q;
            nodes_r[idx_r] <= step_q;
          end
          if (idx_r == IW'(COUNT - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign nodes = nodes_r;

endmodule

// ===== hw/rtl/lsg_div.sv =====
// Pipelined restoring divider that yields one quotient bit per stage.
module lsg_div #(
  parameter int NW = 37,
  parameter int DEN_W = 24,
  parameter int QW = 11,
  parameter int SIDE_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QW-1:0]     quot,
  output logic [SIDE_W-1:0] side_out
);
  logic              v_r [QW];
  logic [NW-1:0]     rem_r [QW];
  logic [DEN_W-1:0]  den_r [QW];
  logic [QW-1:0]     q_r [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic              v_in;
    logic [NW-1:0]     rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QW-1:0]     q_in;
    logic [SIDE_W-1:0] side_sel;
    logic [NW-1:0]     shifted;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign q_in = '0;
      assign side_sel = side_in;
    end else begin : g_next
      assign v_in = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in = q_r[s-1];
      assign side_sel = side_r[s-1];
    end

    assign shifted = NW'(den_in) << K;
    assign ge = (rem_in >= shifted);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_in - shifted) : rem_in;
        q_r[s] <= ge ? (q_in | (QW'(1) << K)) : q_in;
        den_r[s] <= den_in;
        side_r[s] <= side_sel;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot = q_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== hw/rtl/bayer_lens_shading_gain_unit.sv =====
// Top level of the Bayer lens shading gain unit: grid, interpolation, divide and output.
// The unit takes one pixel request per clock while in_stall is low and returns one
// corrected pixel per request, in order, through the clamp, cell search, table lookup,
// weighting, summing and eleven one-bit divider stages plus the output register. An output
// register with a skid entry lets the unit keep taking requests while a result waits.
// After reset and after every write of frame_width or frame_height the grid nodes are
// rebuilt by a reciprocal multiply and an accumulate walk over the nodes; in_stall stays
// high while the rebuild runs.
module bayer_lens_shading_gain_unit #(
  parameter int GAIN_FRAC_BITS = lsg_pkg::DEF_GAIN_FRAC_BITS,
  parameter int MAX_DIM = lsg_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsg_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic [lsg_pkg::COORD_W-1:0]   in_column,
  input  logic [lsg_pkg::COORD_W-1:0]   in_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsg_pkg::OUT_W-1:0]     out_pixel_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsg_pkg::ADDR_W-1:0]    paddr,
  input  logic [lsg_pkg::DATA_W-1:0]    pwdata,
  output logic [lsg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import lsg_pkg::*;

  localparam int DW = $clog2(MAX_DIM);
  localparam int XW = (DW > COORD_W) ? DW : COORD_W;
  localparam int SW = (DW + 1 > SIZE_W) ? DW + 1 : SIZE_W;
  localparam int WW = 2 * DW;
  localparam int TW = WW + GAIN_W;
  localparam int NW = TW + 2;
  localparam int PW = PIX_W + GAIN_W;

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              start_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(height_r) : DATA_W'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= SIZE_RESET;
      height_r <= SIZE_RESET;
      start_r <= 1'b0;
    end else begin
      start_r <= wr_en;
      if (wr_en) begin
        if (paddr[2] == REG_WIDTH) begin
          width_r <= pwdata[SIZE_W-1:0];
        end else begin
          height_r <= pwdata[SIZE_W-1:0];
        end
      end
    end
  end

  function automatic logic [DW-1:0] size_minus_one(input logic [SIZE_W-1:0] v,
                                                   input int lo);
    logic [SW-1:0] e;
    e = SW'(v);
    if (e < SW'(lo)) e = SW'(lo);
    if (e > SW'(MAX_DIM)) e = SW'(MAX_DIM);
    return DW'(e - SW'(1));
  endfunction

  logic [DW-1:0] col_m1;
  logic [DW-1:0] row_m1;
  assign col_m1 = size_minus_one(width_r, GRID_COLS);
  assign row_m1 = size_minus_one(height_r, GRID_ROWS);

  logic col_busy;
  logic row_busy;
  logic [GRID_COLS-1:0][DW-1:0] col_nodes;
  logic [GRID_ROWS-1:0][DW-1:0] row_nodes;

  lsg_grid_axis #(.COUNT(GRID_COLS), .DW(DW)) u_col_axis (
    .clk(clk), .rst_n(rst_n), .start(start_r), .size_m1(col_m1),
    .busy(col_busy), .nodes(col_nodes)
  );

  lsg_grid_axis #(.COUNT(GRID_ROWS), .DW(DW)) u_row_axis (
    .clk(clk), .rst_n(rst_n), .start(start_r), .size_m1(row_m1),
    .busy(row_busy), .nodes(row_nodes)
  );

  logic skid_valid_r;
  logic adv;
  logic in_take;

  assign adv = !skid_valid_r;
  assign in_stall = skid_valid_r || col_busy || row_busy || start_r;
  assign in_take = in_valid && !in_stall;

  // Stage 1: coordinate clamp.
  logic             v1_r;
  logic [PIX_W-1:0] pix1_r;
  logic [DW-1:0]    x1c_r;
  logic [DW-1:0]    y1c_r;
  logic [XW-1:0]    xw;
  logic [XW-1:0]    yw;

  assign xw = (XW'(in_column) > XW'(col_m1)) ? XW'(col_m1) : XW'(in_column);
  assign yw = (XW'(in_row) > XW'(row_m1)) ? XW'(row_m1) : XW'(in_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1_r <= in_pixel_in;
      x1c_r <= DW'(xw);
      y1c_r <= DW'(yw);
    end
  end

  // Stage 2: cell search and distances to the cell edges.
  logic [XI_W-1:0] xi;
  logic [YI_W-1:0] yi;
  logic [DW-1:0]   xlo;
  logic [DW-1:0]   xhi;
  logic [DW-1:0]   ylo;
  logic [DW-1:0]   yhi;

  always_comb begin
    logic gt_c [GRID_COLS];
    logic gt_r [GRID_ROWS];
    logic sel;
    xi = '0;
    xlo = '0;
    xhi = '0;
    yi = '0;
    ylo = '0;
    yhi = '0;
    for (int i = 0; i < GRID_COLS; i++) begin
      gt_c[i] = (i == 0) || ((i < GRID_COLS - 1) && (x1c_r > col_nodes[i]));
    end
    for (int i = 0; i < GRID_ROWS; i++) begin
      gt_r[i] = (i == 0) || ((i < GRID_ROWS - 1) && (y1c_r > row_nodes[i]));
    end
    for (int i = 0; i < GRID_COLS - 1; i++) begin
      sel = gt_c[i] && !gt_c[i+1];
      if (sel) begin
        xi = xi | XI_W'(i);
        xlo = xlo | col_nodes[i];
        xhi = xhi | col_nodes[i+1];
      end
    end
    for (int i = 0; i < GRID_ROWS - 1; i++) begin
      sel = gt_r[i] && !gt_r[i+1];
      if (sel) begin
        yi = yi | YI_W'(i);
        ylo = ylo | row_nodes[i];
        yhi = yhi | row_nodes[i+1];
      end
    end
  end

  logic              v2_r;
  logic [PIX_W-1:0]  pix2_r;
  logic [TSEL_W-1:0] tsel2_r;
  logic [XI_W-1:0]   xi2_r;
  logic [YI_W-1:0]   yi2_r;
  logic [DW-1:0]     dx1_r;
  logic [DW-1:0]     dx2_r;
  logic [DW-1:0]     dy1_r;
  logic [DW-1:0]     dy2_r;
  logic [DW-1:0]     cw_r;
  logic [DW-1:0]     ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix2_r <= pix1_r;
      tsel2_r <= TSEL_W'(x1c_r[0]) + TSEL_W'(y1c_r[0]);
      xi2_r <= xi;
      yi2_r <= yi;
      dx1_r <= x1c_r - xlo;
      dx2_r <= xhi - x1c_r;
      dy1_r <= y1c_r - ylo;
      dy2_r <= yhi - y1c_r;
      cw_r <= xhi - xlo;
      ch_r <= yhi - ylo;
    end
  end

  // Stage 3: corner gains and bilinear weights.
  logic              v3_r;
  logic [PIX_W-1:0]  pix3_r;
  logic [GAIN_W-1:0] g00_r;
  logic [GAIN_W-1:0] g01_r;
  logic [GAIN_W-1:0] g10_r;
  logic [GAIN_W-1:0] g11_r;
  logic [WW-1:0]     w00_r;
  logic [WW-1:0]     w01_r;
  logic [WW-1:0]     w10_r;
  logic [WW-1:0]     w11_r;
  logic [WW-1:0]     den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix3_r <= pix2_r;
      g00_r <= gain_at(tsel2_r, yi2_r, xi2_r);
      g01_r <= gain_at(tsel2_r, yi2_r, xi2_r + XI_W'(1));
      g10_r <= gain_at(tsel2_r, yi2_r + YI_W'(1), xi2_r);
      g11_r <= gain_at(tsel2_r, yi2_r + YI_W'(1), xi2_r + XI_W'(1));
      w00_r <= WW'(dx2_r) * WW'(dy2_r);
      w01_r <= WW'(dx1_r) * WW'(dy2_r);
      w10_r <= WW'(dx2_r) * WW'(dy1_r);
      w11_r <= WW'(dx1_r) * WW'(dy1_r);
      den3_r <= WW'(cw_r) * WW'(ch_r);
    end
  end

  // Stage 4: weighted corner terms.
  logic             v4_r;
  logic [PIX_W-1:0] pix4_r;
  logic [TW-1:0]    t00_r;
  logic [TW-1:0]    t01_r;
  logic [TW-1:0]    t10_r;
  logic [TW-1:0]    t11_r;
  logic [WW-1:0]    den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix4_r <= pix3_r;
      t00_r <= TW'(w00_r) * TW'(g00_r);
      t01_r <= TW'(w01_r) * TW'(g01_r);
      t10_r <= TW'(w10_r) * TW'(g10_r);
      t11_r <= TW'(w11_r) * TW'(g11_r);
      den4_r <= den3_r;
    end
  end

  // Stage 5: numerator sum.
  logic             v5_r;
  logic [PIX_W-1:0] pix5_r;
  logic [NW-1:0]    num5_r;
  logic [WW-1:0]    den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix5_r <= pix4_r;
      num5_r <= NW'(t00_r) + NW'(t01_r) + NW'(t10_r) + NW'(t11_r);
      den5_r <= den4_r;
    end
  end

  logic              vd;
  logic [GAIN_W-1:0] gain_d;
  logic [PIX_W-1:0]  pix_d;

  lsg_div #(.NW(NW), .DEN_W(WW), .QW(GAIN_W), .SIDE_W(PIX_W)) u_div (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v5_r),
    .num(num5_r), .den(den5_r), .side_in(pix5_r),
    .out_valid(vd), .quot(gain_d), .side_out(pix_d)
  );

  // Gain apply, saturation and the output register with its skid entry.
  logic [PW-1:0]    prod;
  logic [PW-1:0]    shifted;
  logic [OUT_W-1:0] sat;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] skid_data_r;
  logic             out_take;

  assign prod = PW'(pix_d) * PW'(gain_d);
  assign shifted = prod >> GAIN_FRAC_BITS;
  assign sat = (shifted > PW'(PIX_MAX)) ? PIX_MAX : OUT_W'(shifted);
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= vd;
      out_data_r <= sat;
    end else if (vd) begin
      skid_data_r <= sat;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel_out = out_data_r;

endmodule

// ===== tb/bayer_lens_shading_gain_checker.sv =====
// Checker for the lens shading gain unit: predicts each corrected pixel and compares it.
`timescale 1ns / 100ps
module bayer_lens_shading_gain_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [lsg_pkg::PIX_W-1:0]   in_pixel_in,
  input  logic [lsg_pkg::COORD_W-1:0] in_column,
  input  logic [lsg_pkg::COORD_W-1:0] in_row,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [lsg_pkg::OUT_W-1:0]   out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [lsg_pkg::DATA_W-1:0]  pwdata,
  output int                          pending,
  output int                          failures,
  output int                          checked
);
  import lsg_pkg::*;

  logic [SIZE_W-1:0] width_reg, height_reg;
  int unsigned eff_w, eff_h;
  int unsigned col_node [GRID_COLS];
  int unsigned row_node [GRID_ROWS];
  logic [OUT_W-1:0] expected_pixels [$];

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void rebuild_grid();
    eff_w = clamp(width_reg, GRID_COLS, DEF_MAX_DIM);
    eff_h = clamp(height_reg, GRID_ROWS, DEF_MAX_DIM);
    for (int i = 0; i < GRID_COLS; i++) col_node[i] = i * (eff_w - 1) / (GRID_COLS - 1);
    for (int j = 0; j < GRID_ROWS; j++) row_node[j] = j * (eff_h - 1) / (GRID_ROWS - 1);
    col_node[GRID_COLS-1] = eff_w - 1;
    row_node[GRID_ROWS-1] = eff_h - 1;
  endfunction

  function automatic logic [OUT_W-1:0] corrected_pixel(logic [PIX_W-1:0] pix,
                                                      logic [COORD_W-1:0] c,
                                                      logic [COORD_W-1:0] r);
    longint unsigned x, y, x1, x2, y1, y2, num, den, gain, prod;
    int xi, yi, ts;
    x = c;
    y = r;
    if (x > eff_w - 1) x = eff_w - 1;
    if (y > eff_h - 1) y = eff_h - 1;
    xi = 0;
    yi = 0;
    for (int i = 1; i < GRID_COLS - 1; i++) if (x > col_node[i]) xi = i;
    for (int j = 1; j < GRID_ROWS - 1; j++) if (y > row_node[j]) yi = j;
    x1 = x - col_node[xi];
    x2 = col_node[xi+1] - x;
    y1 = y - row_node[yi];
    y2 = row_node[yi+1] - y;
    ts = int'(x[0]) + int'(y[0]);
    num = x2 * y2 * GAIN_TABLE[ts][yi][xi] + x1 * y2 * GAIN_TABLE[ts][yi][xi+1]
        + x2 * y1 * GAIN_TABLE[ts][yi+1][xi] + x1 * y1 * GAIN_TABLE[ts][yi+1][xi+1];
    den = (x1 + x2) * (y1 + y2);
    gain = (den != 0) ? num / den : 0;
    prod = (pix * gain) >> DEF_GAIN_FRAC_BITS;
    if (prod > PIX_MAX) prod = PIX_MAX;
    return prod[OUT_W-1:0];
  endfunction

  initial begin
    failures = 0;
    checked = 0;
    pending = 0;
    width_reg = SIZE_RESET;
    height_reg = SIZE_RESET;
    rebuild_grid();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = SIZE_RESET;
      height_reg = SIZE_RESET;
      rebuild_grid();
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg = pwdata[SIZE_W-1:0];
        else height_reg = pwdata[SIZE_W-1:0];
        rebuild_grid();
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(corrected_pixel(in_pixel_in, in_column, in_row));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_pixel_out);
          failures++;
        end else begin
          logic [OUT_W-1:0] exp_pix;
          exp_pix = expected_pixels.pop_front();
          checked++;
          if (exp_pix !== out_pixel_out) begin
            $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                     $time, exp_pix, out_pixel_out);
            failures++;
          end
        end
      end
    end
    pending <= expected_pixels.size();
  end
endmodule

// ===== tb/tb.sv =====
// Top of the lens shading gain testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb;
  import lsg_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [PIX_W-1:0] in_pixel_in;
  logic [COORD_W-1:0] in_column, in_row;
  logic [OUT_W-1:0] out_pixel_out;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int pending, failures, checked;
  bit quiet, long_hold, long_hold_done;
  int unsigned cur_w, cur_h, cycles, sent;

  bayer_lens_shading_gain_unit dut (.*);

  bayer_lens_shading_gain_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("bayer_lens_shading_gain_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_cnt, burst;
    out_stall = 0;
    long_hold_done = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (long_hold && !long_hold_done) begin
        out_stall <= 1;
        hold_cnt++;
        if (hold_cnt >= 300) begin
          long_hold_done = 1;
          out_stall <= 0;
        end
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (burst - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 0;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input int unsigned value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    int unsigned ew, eh;
    wait_drained();
    write_reg(REG_WIDTH_ADDR, w);
    write_reg(REG_HEIGHT_ADDR, h);
    ew = w & 13'h1fff;
    eh = h & 13'h1fff;
    cur_w = (ew < GRID_COLS) ? GRID_COLS : ((ew > DEF_MAX_DIM) ? DEF_MAX_DIM : ew);
    cur_h = (eh < GRID_ROWS) ? GRID_ROWS : ((eh > DEF_MAX_DIM) ? DEF_MAX_DIM : eh);
  endtask

  task automatic send_pixel(input int unsigned pix, input int unsigned c, input int unsigned r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    in_pixel_in <= PIX_W'(pix);
    in_column <= COORD_W'(c);
    in_row <= COORD_W'(r);
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic int unsigned pick_coord(int unsigned size, int unsigned nodes);
    int unsigned k, pos;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom_range(0, 4095);
    if (k < 3) begin
      pos = $urandom_range(0, nodes - 1) * (size - 1) / (nodes - 1);
      pos = pos + $urandom_range(0, 2);
      return (pos == 0) ? 0 : pos - 1;
    end
    return $urandom_range(0, size - 1);
  endfunction

  task automatic random_pixels(input int n);
    int unsigned pix;
    for (int i = 0; i < n; i++) begin
      pix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4095);
      send_pixel(pix, pick_coord(cur_w, GRID_COLS), pick_coord(cur_h, GRID_ROWS));
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_pixel_in = 0;
    in_column = 0;
    in_row = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    quiet = 0;
    long_hold = 0;
    sent = 0;
    cur_w = DEF_MAX_DIM;
    cur_h = DEF_MAX_DIM;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    send_pixel(0, 0, 0);
    send_pixel(65535, 0, 0);
    send_pixel(65535, 4095, 4095);
    send_pixel(4095, 1, 0);
    send_pixel(4095, 0, 1);
    send_pixel(4095, 1, 1);
    send_pixel(1000, 585, 819);
    send_pixel(1000, 586, 820);
    send_pixel(2000, 4094, 4094);
    send_pixel(12345, 2047, 2048);
    send_pixel(65535, 3510, 3276);
    send_pixel(1, 1, 4095);
    random_pixels(50);

    set_frame(8, 6);
    send_pixel(65535, 7, 5);
    send_pixel(65535, 4095, 4095);
    send_pixel(3000, 3, 2);
    random_pixels(40);

    set_frame(0, 0);
    send_pixel(40000, 1, 1);
    random_pixels(30);

    set_frame(8191, 8191);
    long_hold <= 1;
    random_pixels(60);

    set_frame(100, 37);
    random_pixels(60);

    set_frame($urandom_range(8, 4096), $urandom_range(6, 4096));
    random_pixels(60);

    set_frame(4096, 4096);
    quiet = 1;
    random_pixels(60);

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d pixels over seven frame sizes, from the smallest grid to oversized", sent);
    $display("settings, with random stalls and a long output hold; %0d results checked.",
             checked);
    if (failures == 0) begin
      $display("bayer_lens_shading_gain_unit test passed");
    end else begin
      $display("bayer_lens_shading_gain_unit test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/lsg_pkg.sv
hw/rtl/lsg_grid_axis.sv
hw/rtl/lsg_div.sv
hw/rtl/bayer_lens_shading_gain_unit.sv
tb/bayer_lens_shading_gain_checker.sv
tb/tb.sv
